// ===== design/pidta_pkg.sv =====
// Shared types and constants for the trapezoidal PID controller with anti-windup.
// Used by pidta_cfg, pidta_datapath and pid_trapezoid_antiwindup_unit.
package pidta_pkg;

  localparam int DATA_W    = 32;  // Q16.16 sample and gain width
  localparam int FRAC_W    = 16;  // fraction bits
  localparam int INTEG_W   = 48;  // integrator width
  localparam int LIMIT_W   = 31;  // output limit magnitude width
  localparam int CFG_IDX_W = 2;   // register index width

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN         = 2'd0,
    REG_INTEG_GAIN_DT     = 2'd1,
    REG_DERIV_GAIN_PER_DT = 2'd2,
    REG_OUTPUT_LIMIT      = 2'd3
  } cfg_reg_t;

  // Input command codes
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Register reset values
  localparam logic signed [DATA_W-1:0] PROP_GAIN_RST         = 32'sd65536;
  localparam logic signed [DATA_W-1:0] INTEG_GAIN_DT_RST     = 32'sd655;
  localparam logic signed [DATA_W-1:0] DERIV_GAIN_PER_DT_RST = 32'sd65536000;
  localparam logic [LIMIT_W-1:0]       OUTPUT_LIMIT_RST      = 31'd6553600;

  // Gains and limit as seen by the datapath
  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain_dt;
    logic signed [DATA_W-1:0] deriv_gain_per_dt;
    logic [LIMIT_W-1:0]       output_limit;
  } gains_t;

  // Controller state carried from one sample to the next
  typedef struct packed {
    logic signed [INTEG_W-1:0] integral_sum;
    logic signed [DATA_W-1:0]  last_error;
    logic                      sat_flag;
  } pid_state_t;

endpackage

// ===== design/pidta_cfg.sv =====
// Configuration register file: gains and output limit, written through a valid/ready port.
// Depends on pidta_pkg.
module pidta_cfg
  import pidta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output gains_t               gains
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register writes, loaded with defaults at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop_gain         <= PROP_GAIN_RST;
      gains.integ_gain_dt     <= INTEG_GAIN_DT_RST;
      gains.deriv_gain_per_dt <= DERIV_GAIN_PER_DT_RST;
      gains.output_limit      <= OUTPUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:         gains.prop_gain         <= $signed(cfg_data);
        REG_INTEG_GAIN_DT:     gains.integ_gain_dt     <= $signed(cfg_data);
        REG_DERIV_GAIN_PER_DT: gains.deriv_gain_per_dt <= $signed(cfg_data);
        REG_OUTPUT_LIMIT:      gains.output_limit      <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pidta_datapath.sv =====
// One-pass PID: P, trapezoidal I (conditional integration), D, clamp; CLEAR zeroes all.
// Purely combinational; depends on pidta_pkg.
module pidta_datapath
  import pidta_pkg::*;
(
  input  gains_t                   gains,
  input  pid_state_t               state,
  input  logic                     command,
  input  logic signed [DATA_W-1:0] error_value,
  output pid_state_t               state_next,
  output logic signed [DATA_W-1:0] drive_value,
  output logic                     saturated
);

  localparam int PROD_W = 2 * DATA_W;      // gain * Q16.16 sample
  localparam int DPROD_W = 2 * DATA_W + 1; // gain * 33-bit difference
  localparam int SUM_W  = INTEG_W + 4;     // P + I + D with headroom

  logic signed [PROD_W-1:0]   p_full;
  logic signed [PROD_W-1:0]   i_full;
  logic signed [DPROD_W-1:0]  d_full;
  logic signed [DATA_W:0]     err_sum;
  logic signed [DATA_W:0]     err_diff;
  logic signed [DATA_W-1:0]   err_avg;
  logic signed [INTEG_W-1:0]  p_term;
  logic signed [INTEG_W-1:0]  i_step;
  logic signed [INTEG_W:0]    acc;
  logic signed [INTEG_W-1:0]  acc_sat;
  logic signed [INTEG_W-1:0]  i_term;
  logic signed [INTEG_W:0]    d_term;
  logic signed [SUM_W-1:0]    total;
  logic signed [SUM_W-1:0]    lim_pos;
  logic signed [SUM_W-1:0]    lim_neg;
  logic signed [DATA_W-1:0]   lim_word;

  // Trapezoid average and difference against the previous error
  assign err_sum  = (DATA_W+1)'(error_value) + (DATA_W+1)'(state.last_error);
  assign err_diff = (DATA_W+1)'(error_value) - (DATA_W+1)'(state.last_error);
  assign err_avg  = err_sum[DATA_W:1];

  // Products, brought back to Q16.16 by a floor shift
  assign p_full = PROD_W'(gains.prop_gain) * PROD_W'(error_value);
  assign i_full = PROD_W'(gains.integ_gain_dt) * PROD_W'(err_avg);
  assign d_full = DPROD_W'(gains.deriv_gain_per_dt) * DPROD_W'(err_diff);
  assign p_term = p_full[PROD_W-1:FRAC_W];
  assign i_step = i_full[PROD_W-1:FRAC_W];
  assign d_term = d_full[DPROD_W-1:FRAC_W];

  // Integrator update, saturating at the integrator width
  assign acc = (INTEG_W+1)'(state.integral_sum) + (INTEG_W+1)'(i_step);
  always_comb begin
    case (acc[INTEG_W:INTEG_W-1])
      2'b01:   acc_sat = {1'b0, {(INTEG_W-1){1'b1}}};
      2'b10:   acc_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      default: acc_sat = acc[INTEG_W-1:0];
    endcase
  end

  // After a step that hit the limit, the I term is zero and the integral is held
  assign i_term = state.sat_flag ? '0 : acc_sat;

  // Full-width sum and symmetric clamp
  assign total    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
  assign lim_pos  = $signed(SUM_W'(gains.output_limit));
  assign lim_neg  = -lim_pos;
  assign lim_word = $signed(DATA_W'(gains.output_limit));

  always_comb begin
    if (command == CMD_CLEAR) begin
      drive_value = '0;
      saturated   = 1'b0;
      state_next  = '0;
    end else begin
      if (total >= lim_pos) begin
        drive_value = lim_word;
        saturated   = 1'b1;
      end else if (total <= lim_neg) begin
        drive_value = -lim_word;
        saturated   = 1'b1;
      end else begin
        drive_value = total[DATA_W-1:0];
        saturated   = 1'b0;
      end
      state_next.integral_sum = state.sat_flag ? state.integral_sum : acc_sat;
      state_next.last_error   = error_value;
      state_next.sat_flag     = saturated;
    end
  end

endmodule

// ===== design/pid_trapezoid_antiwindup_unit.sv =====
// PID controller, trapezoidal integral with conditional-integration anti-windup, Q16.16.
// Stages: input register, then result register; a result stall holds both.
// Throughput: one word per cycle unless the result channel stalls; the state update (three
// multiplies, sum, clamp) is combinational between the input and result registers.
// Reset: rst is synchronous; it empties both stages, zeroes the controller state and
// loads the default gains and limit.
module pid_trapezoid_antiwindup_unit
  import pidta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // sample channel
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic                     command,
  input  logic signed [DATA_W-1:0] error_value,
  // result channel
  output logic                     drive_valid,
  input  logic                     drive_stall,
  output logic signed [DATA_W-1:0] drive_value,
  output logic                     saturated,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  gains_t                   gains;
  pid_state_t               state;
  pid_state_t               state_next;
  logic                     in_vld;
  logic                     in_cmd;
  logic signed [DATA_W-1:0] in_err;
  logic signed [DATA_W-1:0] calc_drive;
  logic                     calc_sat;
  logic                     accept;
  logic                     advance;

  pidta_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  pidta_datapath u_datapath (
    .gains       (gains),
    .state       (state),
    .command     (in_cmd),
    .error_value (in_err),
    .state_next  (state_next),
    .drive_value (calc_drive),
    .saturated   (calc_sat)
  );

  // Handshake: input stage moves on whenever the result register is free or drains
  assign advance      = in_vld && (!drive_valid || !drive_stall);
  assign sample_stall = in_vld && drive_valid && drive_stall;
  assign accept       = sample_valid && !sample_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd <= command;
      in_err <= error_value;
    end
  end

  // Controller state, committed as the word leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= 1'b1;
    end else if (!drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_value <= calc_drive;
      saturated   <= calc_sat;
    end
  end

endmodule
